>>> rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared widths, operation and step codes, and controller/datapath bundles
// for the paired sample statistics block.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int SampleBits  = 16;
    localparam int CountBits   = 17;
    localparam int TotalBits   = 33;
    localparam int SquareBits  = 47;
    localparam int CrossBits   = 48;
    localparam int WideBits    = 64;
    localparam int DividendBits = 80;
    localparam int DivisorBits = 48;
    localparam int RootBits    = 24;
    localparam int RootRemBits = 25;
    localparam int IterBits    = 7;

    localparam logic [CountBits-1:0] MaxPairs = 17'd65536;

    // iteration counts minus one
    localparam logic [IterBits-1:0] MulIters  = 7'd63;
    localparam logic [IterBits-1:0] DivIters  = 7'd79;
    localparam logic [IterBits-1:0] SqrtIters = 7'd23;

    typedef logic [1:0] op_t;
    localparam op_t OP_MUL  = 2'd0;
    localparam op_t OP_DIV  = 2'd1;
    localparam op_t OP_SQRT = 2'd2;

    typedef logic [3:0] step_t;
    localparam step_t STEP_D    = 4'd0;
    localparam step_t STEP_NSXX = 4'd1;
    localparam step_t STEP_NX   = 4'd2;
    localparam step_t STEP_NSYY = 4'd3;
    localparam step_t STEP_NY   = 4'd4;
    localparam step_t STEP_NSXY = 4'd5;
    localparam step_t STEP_C    = 4'd6;
    localparam step_t STEP_MX   = 4'd7;
    localparam step_t STEP_MY   = 4'd8;
    localparam step_t STEP_VX   = 4'd9;
    localparam step_t STEP_VY   = 4'd10;
    localparam step_t STEP_COV  = 4'd11;
    localparam step_t STEP_DX   = 4'd12;
    localparam step_t STEP_DY   = 4'd13;
    localparam step_t STEP_DD   = 4'd14;
    localparam step_t STEP_CORR = 4'd15;

    typedef struct packed {
        logic  accept;
        logic  start;
        step_t step;
        op_t   op;
        logic  load_out;
    } pss_cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } pss_status_t;

    function automatic op_t step_op(input step_t s);
        op_t o;
        unique case (s)
            STEP_D, STEP_NSXX, STEP_NX, STEP_NSYY, STEP_NY, STEP_NSXY, STEP_C, STEP_DD:
                o = OP_MUL;
            STEP_MX, STEP_MY, STEP_VX, STEP_VY, STEP_COV, STEP_CORR:
                o = OP_DIV;
            STEP_DX, STEP_DY:
                o = OP_SQRT;
            default:
                o = OP_MUL;
        endcase
        return o;
    endfunction

endpackage

>>> rtl/pss_accum.sv
// ----------------------------------------------------------------------------
// pss_accum
// Pair count and exact running sums of x, y, x*x, y*y and x*y.
// ----------------------------------------------------------------------------
module pss_accum (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic                                   clear,
    input  logic signed [15:0]                     sample_x,
    input  logic signed [15:0]                     sample_y,
    output logic [pss_pkg::CountBits-1:0]          count,
    output logic signed [pss_pkg::TotalBits-1:0]   total_first,
    output logic signed [pss_pkg::TotalBits-1:0]   total_second,
    output logic [pss_pkg::SquareBits-1:0]         squares_first,
    output logic [pss_pkg::SquareBits-1:0]         squares_second,
    output logic signed [pss_pkg::CrossBits-1:0]   cross_products
);

    logic signed [pss_pkg::SampleBits-1:0]   x_s;
    logic signed [pss_pkg::SampleBits-1:0]   y_s;
    logic signed [2*pss_pkg::SampleBits-1:0] xx;
    logic signed [2*pss_pkg::SampleBits-1:0] yy;
    logic signed [2*pss_pkg::SampleBits-1:0] xy;

    logic [pss_pkg::CountBits-1:0]        count_reg;
    logic signed [pss_pkg::TotalBits-1:0] total_first_reg;
    logic signed [pss_pkg::TotalBits-1:0] total_second_reg;
    logic [pss_pkg::SquareBits-1:0]       squares_first_reg;
    logic [pss_pkg::SquareBits-1:0]       squares_second_reg;
    logic signed [pss_pkg::CrossBits-1:0] cross_reg;
    logic                                 room;

    assign x_s  = sample_x[pss_pkg::SampleBits-1:0];
    assign y_s  = sample_y[pss_pkg::SampleBits-1:0];
    assign xx   = x_s * x_s;
    assign yy   = y_s * y_s;
    assign xy   = x_s * y_s;
    assign room = count_reg < pss_pkg::MaxPairs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg          <= '0;
            total_first_reg    <= '0;
            total_second_reg   <= '0;
            squares_first_reg  <= '0;
            squares_second_reg <= '0;
            cross_reg          <= '0;
        end
        else if (clear)
        begin
            count_reg          <= '0;
            total_first_reg    <= '0;
            total_second_reg   <= '0;
            squares_first_reg  <= '0;
            squares_second_reg <= '0;
            cross_reg          <= '0;
        end
        else if (accept && room)
        begin
            count_reg          <= count_reg + 1'b1;
            total_first_reg    <= total_first_reg + pss_pkg::TotalBits'(x_s);
            total_second_reg   <= total_second_reg + pss_pkg::TotalBits'(y_s);
            squares_first_reg  <= squares_first_reg
                                  + pss_pkg::SquareBits'(unsigned'(xx));
            squares_second_reg <= squares_second_reg
                                  + pss_pkg::SquareBits'(unsigned'(yy));
            cross_reg          <= cross_reg + pss_pkg::CrossBits'(xy);
        end
    end

    assign count          = count_reg;
    assign total_first    = total_first_reg;
    assign total_second   = total_second_reg;
    assign squares_first  = squares_first_reg;
    assign squares_second = squares_second_reg;
    assign cross_products = cross_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pss_pkg::MaxPairs)
        else $error("pair count ran past the set limit");

endmodule

>>> rtl/pss_arith.sv
// ----------------------------------------------------------------------------
// pss_arith
// Shared iterative unit: shift-add multiply (64 bits, wrapping), restoring
// divide (80-bit dividend, 48-bit divisor) and digit-by-digit square root.
// ----------------------------------------------------------------------------
module pss_arith (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  pss_pkg::op_t                          op,
    input  logic [pss_pkg::DividendBits-1:0]      opa,
    input  logic [pss_pkg::WideBits-1:0]          opb,
    output logic [pss_pkg::WideBits-1:0]          result,
    output logic                                  done
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [pss_pkg::IterBits-1:0]        cnt_reg;
    pss_pkg::op_t                        op_reg;
    logic [pss_pkg::DividendBits-1:0]    x_reg;
    logic [pss_pkg::WideBits-1:0]        y_reg;
    logic [pss_pkg::WideBits-1:0]        r_reg;

    logic [pss_pkg::DivisorBits:0]       div_sh;
    logic [pss_pkg::DivisorBits:0]       div_den;
    logic [pss_pkg::DivisorBits:0]       div_diff;
    logic                                div_ge;
    logic [pss_pkg::RootRemBits+1:0]     sq_sh;
    logic [pss_pkg::RootRemBits+1:0]     sq_trial;
    logic [pss_pkg::RootRemBits+1:0]     sq_diff;
    logic                                sq_ge;
    logic [pss_pkg::WideBits-1:0]        mul_sum;

    assign div_sh   = {r_reg[pss_pkg::DivisorBits-1:0], x_reg[pss_pkg::DividendBits-1]};
    assign div_den  = {1'b0, y_reg[pss_pkg::DivisorBits-1:0]};
    assign div_ge   = div_sh >= div_den;
    assign div_diff = div_sh - div_den;

    // remainder gets the next two radicand bits, trial is 4*root + 1
    assign sq_sh    = {r_reg[pss_pkg::RootRemBits-1:0],
                       x_reg[pss_pkg::DividendBits-1:pss_pkg::DividendBits-2]};
    assign sq_trial = {1'b0, y_reg[pss_pkg::RootBits-1:0], 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_diff  = sq_sh - sq_trial;

    assign mul_sum  = x_reg[0] ? r_reg + y_reg : r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= pss_pkg::OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= op;
                unique case (op)
                    pss_pkg::OP_MUL:  cnt_reg <= pss_pkg::MulIters;
                    pss_pkg::OP_DIV:  cnt_reg <= pss_pkg::DivIters;
                    pss_pkg::OP_SQRT: cnt_reg <= pss_pkg::SqrtIters;
                    default:          cnt_reg <= pss_pkg::MulIters;
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= opa;
            y_reg <= opb;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                pss_pkg::OP_MUL:
                begin
                    r_reg <= mul_sum;
                    y_reg <= {y_reg[pss_pkg::WideBits-2:0], 1'b0};
                    x_reg <= {1'b0, x_reg[pss_pkg::DividendBits-1:1]};
                end
                pss_pkg::OP_DIV:
                begin
                    r_reg <= pss_pkg::WideBits'(div_ge ? div_diff[pss_pkg::DivisorBits-1:0]
                                                       : div_sh[pss_pkg::DivisorBits-1:0]);
                    x_reg <= {x_reg[pss_pkg::DividendBits-2:0], div_ge};
                end
                pss_pkg::OP_SQRT:
                begin
                    r_reg <= pss_pkg::WideBits'(sq_ge ? sq_diff[pss_pkg::RootRemBits-1:0]
                                                      : sq_sh[pss_pkg::RootRemBits-1:0]);
                    y_reg <= pss_pkg::WideBits'({y_reg[pss_pkg::RootBits-2:0], sq_ge});
                    x_reg <= {x_reg[pss_pkg::DividendBits-3:0], 2'b00};
                end
                default:
                begin
                    r_reg <= r_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (op_reg)
            pss_pkg::OP_MUL:  result = r_reg;
            pss_pkg::OP_DIV:  result = x_reg[pss_pkg::WideBits-1:0];
            pss_pkg::OP_SQRT: result = pss_pkg::WideBits'(y_reg[pss_pkg::RootBits-1:0]);
            default:          result = r_reg;
        endcase
    end

    assign done = done_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("operation started while unit busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

endmodule

>>> rtl/pss_datapath.sv
// ----------------------------------------------------------------------------
// pss_datapath
// Accumulators, shared arithmetic unit, intermediate registers and the
// result output register.
// ----------------------------------------------------------------------------
module pss_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pss_pkg::pss_cmd_t        cmd,
    output pss_pkg::pss_status_t     status,
    input  logic signed [15:0]       sample_x,
    input  logic signed [15:0]       sample_y,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic [16:0]              pair_count,
    output logic signed [23:0]       mean_first,
    output logic signed [23:0]       mean_second,
    output logic [38:0]              variance_first,
    output logic [38:0]              variance_second,
    output logic [23:0]              deviation_first,
    output logic [23:0]              deviation_second,
    output logic signed [39:0]       covariance,
    output logic signed [15:0]       correlation,
    output logic                     zero_deviation
);

    logic [pss_pkg::CountBits-1:0]        count;
    logic signed [pss_pkg::TotalBits-1:0] total_first;
    logic signed [pss_pkg::TotalBits-1:0] total_second;
    logic [pss_pkg::SquareBits-1:0]       squares_first;
    logic [pss_pkg::SquareBits-1:0]       squares_second;
    logic signed [pss_pkg::CrossBits-1:0] cross_products;

    logic [pss_pkg::DividendBits-1:0] opa;
    logic [pss_pkg::WideBits-1:0]     opb;
    logic [pss_pkg::WideBits-1:0]     result;
    logic                             done;

    logic [pss_pkg::WideBits-1:0]  n64;
    logic [pss_pkg::WideBits-1:0]  sx64;
    logic [pss_pkg::WideBits-1:0]  sy64;
    logic [pss_pkg::TotalBits-1:0] sx_mag;
    logic [pss_pkg::TotalBits-1:0] sy_mag;
    logic [pss_pkg::WideBits-1:0]  c_diff;
    logic [23:0]                   q_neg;
    logic [14:0]                   q_clamp;

    logic [32:0] d_reg;
    logic [63:0] tmp_reg;
    logic [63:0] nx_reg;
    logic [63:0] ny_reg;
    logic        cneg_reg;
    logic [63:0] cmag_reg;
    logic [23:0] mean_x_reg;
    logic [23:0] mean_y_reg;
    logic [46:0] vx16_reg;
    logic [46:0] vy16_reg;
    logic [38:0] covmag_reg;
    logic [23:0] dx_reg;
    logic [23:0] dy_reg;
    logic [47:0] prod_reg;
    logic [15:0] corr_reg;
    logic        zero_reg;

    logic        result_valid_reg;
    logic [16:0] pair_count_reg;
    logic [23:0] mean_first_reg;
    logic [23:0] mean_second_reg;
    logic [38:0] variance_first_reg;
    logic [38:0] variance_second_reg;
    logic [23:0] deviation_first_reg;
    logic [23:0] deviation_second_reg;
    logic [39:0] covariance_reg;
    logic [15:0] correlation_reg;
    logic        zero_deviation_reg;

    pss_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (cmd.accept),
        .clear          (cmd.load_out),
        .sample_x       (sample_x),
        .sample_y       (sample_y),
        .count          (count),
        .total_first    (total_first),
        .total_second   (total_second),
        .squares_first  (squares_first),
        .squares_second (squares_second),
        .cross_products (cross_products)
    );

    pss_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .op     (cmd.op),
        .opa    (opa),
        .opb    (opb),
        .result (result),
        .done   (done)
    );

    assign n64    = pss_pkg::WideBits'(count);
    assign sx64   = pss_pkg::WideBits'(total_first);
    assign sy64   = pss_pkg::WideBits'(total_second);
    assign sx_mag = total_first[pss_pkg::TotalBits-1] ? unsigned'(-total_first)
                                                      : unsigned'(total_first);
    assign sy_mag = total_second[pss_pkg::TotalBits-1] ? unsigned'(-total_second)
                                                       : unsigned'(total_second);
    assign c_diff  = tmp_reg - result;
    assign q_neg   = ~result[23:0] + 24'd1;
    assign q_clamp = (result > 64'd16384) ? 15'd16384 : result[14:0];

    // operands for the step about to start
    always_comb
    begin
        opa = '0;
        opb = '0;
        unique case (cmd.step)
            pss_pkg::STEP_D:    begin opa = pss_pkg::DividendBits'(n64);  opb = n64; end
            pss_pkg::STEP_NSXX:
            begin
                opa = pss_pkg::DividendBits'(n64);
                opb = pss_pkg::WideBits'(squares_first);
            end
            pss_pkg::STEP_NX:   begin opa = pss_pkg::DividendBits'(sx64); opb = sx64; end
            pss_pkg::STEP_NSYY:
            begin
                opa = pss_pkg::DividendBits'(n64);
                opb = pss_pkg::WideBits'(squares_second);
            end
            pss_pkg::STEP_NY:   begin opa = pss_pkg::DividendBits'(sy64); opb = sy64; end
            pss_pkg::STEP_NSXY:
            begin
                opa = pss_pkg::DividendBits'(n64);
                opb = pss_pkg::WideBits'(cross_products);
            end
            pss_pkg::STEP_C:    begin opa = pss_pkg::DividendBits'(sx64); opb = sy64; end
            pss_pkg::STEP_MX:
            begin
                opa = pss_pkg::DividendBits'({sx_mag, 8'b0});
                opb = n64;
            end
            pss_pkg::STEP_MY:
            begin
                opa = pss_pkg::DividendBits'({sy_mag, 8'b0});
                opb = n64;
            end
            pss_pkg::STEP_VX:   begin opa = {nx_reg, 16'b0}; opb = 64'(d_reg); end
            pss_pkg::STEP_VY:   begin opa = {ny_reg, 16'b0}; opb = 64'(d_reg); end
            pss_pkg::STEP_COV:
            begin
                opa = pss_pkg::DividendBits'({cmag_reg, 8'b0});
                opb = 64'(d_reg);
            end
            pss_pkg::STEP_DX:   opa = {1'b0, vx16_reg, 32'b0};
            pss_pkg::STEP_DY:   opa = {1'b0, vy16_reg, 32'b0};
            pss_pkg::STEP_DD:
            begin
                opa = pss_pkg::DividendBits'(dx_reg);
                opb = 64'(dy_reg);
            end
            pss_pkg::STEP_CORR:
            begin
                opa = pss_pkg::DividendBits'({covmag_reg, 22'b0});
                opb = 64'(prod_reg);
            end
            default:            opa = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            unique case (cmd.step)
                pss_pkg::STEP_D:    d_reg   <= result[32:0];
                pss_pkg::STEP_NSXX,
                pss_pkg::STEP_NSYY,
                pss_pkg::STEP_NSXY: tmp_reg <= result;
                pss_pkg::STEP_NX:   nx_reg  <= c_diff;
                pss_pkg::STEP_NY:   ny_reg  <= c_diff;
                pss_pkg::STEP_C:
                begin
                    cneg_reg <= c_diff[63];
                    cmag_reg <= c_diff[63] ? ~c_diff + 64'd1 : c_diff;
                end
                pss_pkg::STEP_MX:
                    mean_x_reg <= total_first[pss_pkg::TotalBits-1] ? q_neg : result[23:0];
                pss_pkg::STEP_MY:
                    mean_y_reg <= total_second[pss_pkg::TotalBits-1] ? q_neg : result[23:0];
                pss_pkg::STEP_VX:   vx16_reg   <= result[46:0];
                pss_pkg::STEP_VY:   vy16_reg   <= result[46:0];
                pss_pkg::STEP_COV:  covmag_reg <= result[38:0];
                pss_pkg::STEP_DX:   dx_reg     <= result[23:0];
                pss_pkg::STEP_DY:   dy_reg     <= result[23:0];
                pss_pkg::STEP_DD:   prod_reg   <= result[47:0];
                pss_pkg::STEP_CORR:
                begin
                    if (dx_reg == '0 || dy_reg == '0)
                    begin
                        zero_reg <= 1'b1;
                        corr_reg <= '0;
                    end
                    else
                    begin
                        zero_reg <= 1'b0;
                        corr_reg <= cneg_reg ? ~{1'b0, q_clamp} + 16'd1 : {1'b0, q_clamp};
                    end
                end
                default:            tmp_reg <= tmp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pair_count_reg       <= count;
            mean_first_reg       <= mean_x_reg;
            mean_second_reg      <= mean_y_reg;
            variance_first_reg   <= vx16_reg[46:8];
            variance_second_reg  <= vy16_reg[46:8];
            deviation_first_reg  <= dx_reg;
            deviation_second_reg <= dy_reg;
            covariance_reg       <= cneg_reg ? ~{1'b0, covmag_reg} + 40'd1
                                             : {1'b0, covmag_reg};
            correlation_reg      <= corr_reg;
            zero_deviation_reg   <= zero_reg;
        end
    end

    assign status.done     = done;
    assign status.out_free = !result_valid_reg || !result_stall;

    assign result_valid     = result_valid_reg;
    assign pair_count       = pair_count_reg;
    assign mean_first       = mean_first_reg;
    assign mean_second      = mean_second_reg;
    assign variance_first   = variance_first_reg;
    assign variance_second  = variance_second_reg;
    assign deviation_first  = deviation_first_reg;
    assign deviation_second = deviation_second_reg;
    assign covariance       = covariance_reg;
    assign correlation      = correlation_reg;
    assign zero_deviation   = zero_deviation_reg;

endmodule

>>> rtl/pss_ctrl.sv
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer: takes pairs, then walks the fixed list of arithmetic steps
// and hands the finished set to the output register.
// ----------------------------------------------------------------------------
module pss_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  last_pair,
    output logic                  sample_stall,
    input  pss_pkg::pss_status_t  status,
    output pss_pkg::pss_cmd_t     cmd
);

    localparam logic [1:0] ST_ACCUM = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    pss_pkg::step_t step_reg;
    pss_pkg::step_t step_next;
    logic           accept;

    assign accept       = sample_valid && (state_reg == ST_ACCUM);
    assign sample_stall = state_reg != ST_ACCUM;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (accept && last_pair)
                begin
                    state_next = ST_ISSUE;
                    step_next  = pss_pkg::STEP_D;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.done)
                begin
                    if (step_reg == pss_pkg::STEP_CORR)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        step_next  = step_reg + 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg  <= pss_pkg::STEP_D;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign cmd.accept   = accept;
    assign cmd.start    = state_reg == ST_ISSUE;
    assign cmd.step     = step_reg;
    assign cmd.op       = pss_pkg::step_op(step_reg);
    assign cmd.load_out = (state_reg == ST_OUT) && status.out_free;

    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> state_reg == ST_RUN)
        else $error("arithmetic done outside of a running step");

endmodule

>>> rtl/paired_sample_statistics_top.sv
// ----------------------------------------------------------------------------
// paired_sample_statistics_top
// Means, variances, deviations, covariance and correlation of a set of
// signed sample pairs closed by a last marker.
// Throughput: one pair per cycle while a set is accumulated.
// After a last pair the shared bit-serial unit runs the fixed list of steps
// (8 multiplies of 64 bits, 6 divides of 80-bit dividends, 2 roots of 24 bits).
// Input is stalled while the steps run; a result still waiting holds the
// next finished set before the output register, and the input with it.
// Reset clears the accumulators and leaves no result pending.
// ----------------------------------------------------------------------------
module paired_sample_statistics_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic signed [15:0]  sample_x,
    input  logic signed [15:0]  sample_y,
    input  logic                last_pair,
    input  logic                sample_valid,
    output logic                sample_stall,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [16:0]         pair_count,
    output logic signed [23:0]  mean_first,
    output logic signed [23:0]  mean_second,
    output logic [38:0]         variance_first,
    output logic [38:0]         variance_second,
    output logic [23:0]         deviation_first,
    output logic [23:0]         deviation_second,
    output logic signed [39:0]  covariance,
    output logic signed [15:0]  correlation,
    output logic                zero_deviation
);

    pss_pkg::pss_cmd_t    cmd;
    pss_pkg::pss_status_t status;

    pss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .last_pair    (last_pair),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    pss_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .sample_x         (sample_x),
        .sample_y         (sample_y),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .pair_count       (pair_count),
        .mean_first       (mean_first),
        .mean_second      (mean_second),
        .variance_first   (variance_first),
        .variance_second  (variance_second),
        .deviation_first  (deviation_first),
        .deviation_second (deviation_second),
        .covariance       (covariance),
        .correlation      (correlation),
        .zero_deviation   (zero_deviation)
    );

endmodule
